[hdl/bpf_pkg.sv]
// Shared constants, command codes and status type for the bad pixel fill core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package bpf_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned DIM_MAX    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DIM_W      = $clog2(DIM_MAX + 1);
  localparam int unsigned RING_SIZE  = 2 * MAX_WIDTH + 4;
  localparam int unsigned RING_AW    = $clog2(RING_SIZE);
  localparam int unsigned STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned POS_W      = $clog2(STORE_SIZE);
  localparam int unsigned NPIX_W     = $clog2(STORE_SIZE + 1);

  // shared divider: position / width, fill mean and rolling mean
  localparam int unsigned DIV_NW  = (POS_W > 24) ? POS_W : 24;
  localparam int unsigned DIV_DW  = (DIM_W > 10) ? DIM_W : 10;
  localparam int unsigned DIV_CW  = $clog2(DIV_NW);

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned PIX_W   = 14;
  localparam int unsigned WT_W    = 8;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned SUM_W   = 21;

  // register indexes
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_ROLLING_WEIGHT = 2'd2;

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SETUP,
    CMD_ROWCOL,
    CMD_NBADDR,
    CMD_NBACC,
    CMD_FILLDIV,
    CMD_FILLDONE,
    CMD_PLAIN,
    CMD_AVGRD,
    CMD_AVGMUL,
    CMD_AVGDIV,
    CMD_AVGDONE,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic emit;
    logic fill;
    logic wsum_zero;
    logic avg_on;
    logic div_busy;
    logic nb_last;
    logic out_free;
  } status_t;

endpackage

[hdl/bpf_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on bpf_pkg for widths.
`timescale 1ns / 1ps
module bpf_div import bpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] dividend_i,
  input  logic [DIV_DW-1:0] divisor_i,
  output logic              busy_o,
  output logic [DIV_NW-1:0] quot_o,
  output logic [DIV_DW-1:0] rem_o
);

  logic              busy_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW-1:0] rem_q, rem_d, div_q;
  logic [DIV_DW:0]   part;
  logic              ge;

  always_comb begin
    part  = {rem_q, quo_q[DIV_NW-1]};
    ge    = (part >= {1'b0, div_q});
    rem_d = ge ? DIV_DW'(part - {1'b0, div_q}) : part[DIV_DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_NW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[hdl/bpf_datapath.sv]
// Datapath: config registers, line ring, frame average store, accumulators, output beat.
// Depends on bpf_pkg and bpf_div; driven by commands from bpf_ctrl.
`timescale 1ns / 1ps
module bpf_datapath import bpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_e              cmd_i,
  output status_t           status_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              op_i,
  input  logic [RAW_W-1:0]  raw_i,
  input  logic              bad_i,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output logic [PIX_W-1:0]  pix_o,
  output logic              last_o
);

  logic [CFG_W-1:0] width_q, height_q;
  logic [WT_W-1:0]  weight_q;
  logic             avg_valid_q;

  logic [DIM_W-1:0]  w_c, h_c;
  logic [NPIX_W-1:0] npix_q;

  logic [RAW_W:0]    ring_mem [RING_SIZE];
  logic [RAW_W:0]    ring_rd_q;
  logic [RING_AW-1:0] raddr_q, head_q, k_q;
  logic [RING_AW:0]  pending_q;
  logic              emit_q;

  logic [PIX_W-1:0]  avg_mem [STORE_SIZE];
  logic [PIX_W-1:0]  avg_rd_q;

  logic [POS_W-1:0]  out_pos_q, pos_q, pos_sel;
  logic              last_q;
  logic [DIM_W-1:0]  row_q, col_q;
  logic [RAW_W:0]    center_q;
  logic [RAW_W-1:0]  val_q;
  logic [2:0]        nb_q;
  logic [SUM_W-1:0]  sum_q;
  logic [3:0]        wsum_q;
  logic [21:0]       prod_q;
  logic [PIX_W-1:0]  res_q;

  logic [PIX_W-1:0]  out_data_q;
  logic              out_last_q, out_valid_q;

  logic              div_start, div_busy;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den, div_rem;

  logic signed [RING_AW+1:0] kx, wx, tnb, one_x;
  logic [RING_AW-1:0] nb_addr, k_new;
  logic [RING_AW:0]   k_diff;
  logic               corner;
  logic [PIX_W-1:0]   v14;
  logic [22:0]        avg_part;
  logic [DIV_NW-1:0]  avg_num;

  // clamp the frame size to its legal range
  always_comb begin
    if (width_q < CFG_W'(3))                         w_c = DIM_W'(3);
    else if ({1'b0, width_q} > (CFG_W + 1)'(MAX_WIDTH)) w_c = DIM_W'(MAX_WIDTH);
    else                                             w_c = DIM_W'(width_q);
    if (height_q < CFG_W'(3))                         h_c = DIM_W'(3);
    else if ({1'b0, height_q} > (CFG_W + 1)'(MAX_HEIGHT)) h_c = DIM_W'(MAX_HEIGHT);
    else                                              h_c = DIM_W'(height_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1024);
      height_q <= CFG_W'(1024);
      weight_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:    width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT:   height_q <= cfg_data_i;
        REG_ROLLING_WEIGHT: weight_q <= cfg_data_i[WT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    npix_q <= NPIX_W'(w_c) * NPIX_W'(h_c);
  end

  // ring read index of the oldest pending pixel
  always_comb begin
    k_diff = {1'b0, head_q} - pending_q;
    if ({1'b0, head_q} < pending_q) k_new = RING_AW'(k_diff + (RING_AW + 1)'(RING_SIZE));
    else                            k_new = k_diff[RING_AW-1:0];
    pos_sel = ({1'b0, out_pos_q} >= npix_q) ? '0 : out_pos_q;
  end

  // neighbor address, wrapped into the ring
  always_comb begin
    kx    = $signed({2'b00, k_q});
    wx    = $signed((RING_AW + 2)'(w_c));
    one_x = $signed((RING_AW + 2)'(1));
    case (nb_q)
      3'd0:    tnb = kx - wx - one_x;
      3'd1:    tnb = kx - wx;
      3'd2:    tnb = kx - wx + one_x;
      3'd3:    tnb = kx - one_x;
      3'd4:    tnb = kx + one_x;
      3'd5:    tnb = kx + wx - one_x;
      3'd6:    tnb = kx + wx;
      default: tnb = kx + wx + one_x;
    endcase
    if (tnb < 0)                                     nb_addr = RING_AW'(tnb + RING_SIZE);
    else if (tnb >= $signed((RING_AW + 2)'(RING_SIZE))) nb_addr = RING_AW'(tnb - RING_SIZE);
    else                                             nb_addr = tnb[RING_AW-1:0];
    corner = (nb_q inside {3'd0, 3'd2, 3'd5, 3'd7});
  end

  assign v14      = val_q[RAW_W-1:2];
  assign avg_part = 23'(prod_q) + 23'(v14);
  assign avg_num  = DIV_NW'({avg_part, 1'b0}) + DIV_NW'(weight_q) + DIV_NW'(1);

  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_NW'(pos_sel);
    div_den   = DIV_DW'(w_c);
    case (cmd_i)
      CMD_SETUP: div_start = 1'b1;
      CMD_FILLDIV: begin
        div_start = 1'b1;
        div_num   = DIV_NW'({sum_q, 1'b0}) + DIV_NW'(wsum_q);
        div_den   = DIV_DW'({wsum_q, 1'b0});
      end
      CMD_AVGDIV: begin
        div_start = 1'b1;
        div_num   = avg_num;
        div_den   = DIV_DW'({(WT_W + 1)'(weight_q) + 1'b1, 1'b0});
      end
      default: ;
    endcase
  end

  bpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD && op_i == OP_PIXEL) ring_mem[head_q] <= {bad_i, raw_i};
    ring_rd_q <= ring_mem[raddr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_EMIT)  avg_mem[pos_q] <= res_q;
    if (cmd_i == CMD_AVGRD) avg_rd_q <= avg_mem[pos_q];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      pending_q   <= '0;
      out_pos_q   <= '0;
      avg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      emit_q      <= 1'b0;
    end else begin
      if (out_valid_q && m_tready_i) out_valid_q <= 1'b0;
      if (cfg_we_i && cfg_idx_i == REG_ROLLING_WEIGHT && cfg_data_i[WT_W-1:0] == '0)
        avg_valid_q <= 1'b0;
      case (cmd_i)
        CMD_LOAD: begin
          if (op_i == OP_PIXEL) begin
            head_q    <= (head_q == RING_AW'(RING_SIZE - 1)) ? '0 : head_q + 1'b1;
            pending_q <= pending_q + 1'b1;
            emit_q    <= (pending_q >= (RING_AW + 1)'(w_c) + 1'b1);
          end else begin
            emit_q    <= (pending_q != '0);
          end
        end
        CMD_SETUP: pending_q <= pending_q - 1'b1;
        CMD_EMIT: begin
          out_valid_q <= 1'b1;
          if (last_q) begin
            avg_valid_q <= (weight_q != '0);
            out_pos_q   <= '0;
          end else begin
            out_pos_q   <= pos_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_SETUP: begin
        k_q     <= k_new;
        raddr_q <= k_new;
        pos_q   <= pos_sel;
        last_q  <= ({1'b0, pos_sel} == npix_q - 1'b1);
        nb_q    <= '0;
        sum_q   <= '0;
        wsum_q  <= '0;
      end
      CMD_ROWCOL: begin
        row_q    <= div_quot[DIM_W-1:0];
        col_q    <= div_rem[DIM_W-1:0];
        center_q <= ring_rd_q;
        val_q    <= ring_rd_q[RAW_W-1:0];
      end
      CMD_NBADDR: raddr_q <= nb_addr;
      CMD_NBACC: begin
        nb_q <= nb_q + 1'b1;
        if (!ring_rd_q[RAW_W]) begin
          sum_q  <= sum_q + (corner ? SUM_W'(ring_rd_q[RAW_W-1:0])
                                    : SUM_W'({ring_rd_q[RAW_W-1:0], 1'b0}));
          wsum_q <= wsum_q + (corner ? 4'd1 : 4'd2);
        end
      end
      CMD_FILLDONE: val_q  <= div_quot[RAW_W-1:0];
      CMD_PLAIN:    res_q  <= v14;
      CMD_AVGMUL:   prod_q <= avg_rd_q * weight_q;
      CMD_AVGDONE:  res_q  <= div_quot[PIX_W-1:0];
      CMD_EMIT: begin
        out_data_q <= res_q;
        out_last_q <= last_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.emit      = emit_q;
    status_o.fill      = center_q[RAW_W] && (row_q != '0) && (col_q != '0)
                         && ((DIM_W + 1)'(row_q) + 2'd2 <= (DIM_W + 1)'(h_c))
                         && ((DIM_W + 1)'(col_q) + 2'd2 <= (DIM_W + 1)'(w_c));
    status_o.wsum_zero = (wsum_q == '0);
    status_o.avg_on    = (weight_q != '0) && avg_valid_q;
    status_o.div_busy  = div_busy;
    status_o.nb_last   = (nb_q == 3'd7);
    status_o.out_free  = !out_valid_q || m_tready_i;
  end

  assign m_tvalid_o = out_valid_q;
  assign pix_o      = out_data_q;
  assign last_o     = out_last_q;

endmodule

[hdl/bpf_ctrl.sv]
// Controller: sequences one item through the datapath by command codes.
// Depends on bpf_pkg for the command and status types.
`timescale 1ns / 1ps
module bpf_ctrl import bpf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  input  status_t status_i,
  output cmd_e    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_DIVPOS, ST_CHKFILL, ST_NBADDR, ST_NBWAIT, ST_NBACC,
    ST_FILLDIV, ST_FILLWAIT, ST_AVGSEL, ST_AVGMUL, ST_AVGDIV, ST_AVGWAIT, ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      ST_IDLE: if (s_tvalid_i) begin
        cmd_o = CMD_LOAD;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.emit) begin
          cmd_o = CMD_SETUP;
          state_d = ST_DIVPOS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVPOS: if (!status_i.div_busy) begin
        cmd_o = CMD_ROWCOL;
        state_d = ST_CHKFILL;
      end
      ST_CHKFILL: state_d = status_i.fill ? ST_NBADDR : ST_AVGSEL;
      ST_NBADDR: begin
        cmd_o = CMD_NBADDR;
        state_d = ST_NBWAIT;
      end
      ST_NBWAIT: state_d = ST_NBACC;
      ST_NBACC: begin
        cmd_o = CMD_NBACC;
        state_d = status_i.nb_last ? ST_FILLDIV : ST_NBADDR;
      end
      ST_FILLDIV: begin
        // no usable neighbor: keep the raw value
        if (status_i.wsum_zero) begin
          state_d = ST_AVGSEL;
        end else begin
          cmd_o = CMD_FILLDIV;
          state_d = ST_FILLWAIT;
        end
      end
      ST_FILLWAIT: if (!status_i.div_busy) begin
        cmd_o = CMD_FILLDONE;
        state_d = ST_AVGSEL;
      end
      ST_AVGSEL: begin
        if (status_i.avg_on) begin
          cmd_o = CMD_AVGRD;
          state_d = ST_AVGMUL;
        end else begin
          cmd_o = CMD_PLAIN;
          state_d = ST_OUT;
        end
      end
      ST_AVGMUL: begin
        cmd_o = CMD_AVGMUL;
        state_d = ST_AVGDIV;
      end
      ST_AVGDIV: begin
        cmd_o = CMD_AVGDIV;
        state_d = ST_AVGWAIT;
      end
      ST_AVGWAIT: if (!status_i.div_busy) begin
        cmd_o = CMD_AVGDONE;
        state_d = ST_OUT;
      end
      ST_OUT: if (status_i.out_free) begin
        cmd_o = CMD_EMIT;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign s_tready_o = (state_q == ST_IDLE);

endmodule

[hdl/bad_pixel_fill_rolling_average_core.sv]
// Top level of the bad pixel fill and rolling frame average core.
// Depends on bpf_pkg, bpf_ctrl and bpf_datapath.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata = raw_pixel; tuser = op, pixel_bad
//   m_axis    out  tvalid/tready          tdata = pixel_out; tlast = frame_last
//   cfg       in   cfg_we_i (no stall)    cfg_idx_i, cfg_data_i
//
// A pixel beat that causes no output only loads the ring. A beat that emits divides its
// position by the width; a flagged interior pixel then reads its eight neighbors one at a
// time through the single ring read port, and divides for the fill mean if any is usable;
// averaging adds a store read, a multiply and another pass through the shared 24-step divider.
// The line ring and frame store get no clearing pass: entries are undefined until written.
// A waiting output beat stalls only the final step of the next emitting item.
`timescale 1ns / 1ps
module bad_pixel_fill_rolling_average_core import bpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] raw_pixel
  input  logic [1:0]        s_axis_tuser,   // [0] op, [1] pixel_bad
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [13:0] pixel_out, [15:14] zero
  output logic              m_axis_tlast,   // frame_last
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  cmd_e             cmd;
  status_t          status;
  logic [PIX_W-1:0] pix;

  bpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bpf_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .op_i       (s_axis_tuser[0]),
    .raw_i      (s_axis_tdata),
    .bad_i      (s_axis_tuser[1]),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .pix_o      (pix),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, pix};

endmodule

[test/testbench.sv]
// Self-checking testbench for bad_pixel_fill_rolling_average_core.
// Depends on bpf_pkg and the core; a built-in predictor checks every output beat.
`timescale 1ns / 1ps
module testbench;
  import bpf_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] raw;
    logic        bad;
  } pix_item_t;

  typedef struct {
    logic [13:0] pixel;
    logic        last;
  } out_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  bad_pixel_fill_rolling_average_core DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // predictor state
  int unsigned    cfg_width, cfg_height, cfg_weight;
  bit [16:0]      ring_mem [RING_SIZE];
  int unsigned    ring_head, ring_pending, next_pos;
  bit [13:0]      avg_mem [STORE_SIZE];
  bit             avg_valid;

  pix_item_t      pixel_q [$];
  out_beat_t      expected_q [$];
  pix_item_t      cur_item;

  int             send_idle, recv_idle;
  int             errors, beats_out, frames_out, items_in;
  bit             hold_req;
  int             hold_cnt;
  int             quiet_cycles;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned fill_mean(int unsigned k, int unsigned w);
    int unsigned sum, wsum, m, idx;
    bit [16:0] e;
    sum = 0;
    wsum = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (dx == 0 && dy == 0) continue;
        idx = (int'(k) + 2 * int'(RING_SIZE) + dy * int'(w) + dx) % RING_SIZE;
        e = ring_mem[idx];
        if (e[16]) continue;
        m = (dx != 0 && dy != 0) ? 1 : 2;
        sum += m * e[15:0];
        wsum += m;
      end
    end
    if (wsum == 0) return ring_mem[k][15:0];
    return (2 * sum + wsum) / (2 * wsum);
  endfunction

  task automatic predict_beat(input pix_item_t it);
    int unsigned w, h, npix, k, pos, row, col, val, v14, res;
    bit last;
    bit [16:0] e;
    out_beat_t ob;
    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    npix = w * h;
    if (it.op == OP_PIXEL) begin
      ring_mem[ring_head] = {it.bad, it.raw};
      ring_head = (ring_head + 1) % RING_SIZE;
      ring_pending++;
      if (ring_pending <= w + 1) return;
    end else if (ring_pending == 0) begin
      return;
    end
    k = (ring_head + RING_SIZE - ring_pending) % RING_SIZE;
    ring_pending--;
    pos = next_pos;
    if (pos >= npix) pos = 0;
    row = pos / w;
    col = pos % w;
    last = (pos == npix - 1);
    e = ring_mem[k];
    val = e[15:0];
    if (e[16] && row >= 1 && row + 2 <= h && col >= 1 && col + 2 <= w) val = fill_mean(k, w);
    v14 = val >> 2;
    if (cfg_weight != 0 && avg_valid)
      res = (2 * (avg_mem[pos] * cfg_weight + v14) + cfg_weight + 1) / (2 * (cfg_weight + 1));
    else
      res = v14;
    res &= 14'h3FFF;
    avg_mem[pos] = res[13:0];
    if (last) begin
      avg_valid = (cfg_weight != 0);
      next_pos = 0;
    end else begin
      next_pos = pos + 1;
    end
    ob.pixel = res[13:0];
    ob.last = last;
    expected_q.push_back(ob);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(cur_item);
        items_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_item = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_item.raw;
          s_axis_tuser  <= {cur_item.bad, cur_item.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("output beat with no expectation: pixel_out %0d", m_axis_tdata[13:0]);
          errors++;
        end else begin
          out_beat_t ob;
          ob = expected_q.pop_front();
          if (m_axis_tdata[13:0] !== ob.pixel) begin
            $error("pixel_out expected %0d actual %0d", ob.pixel, m_axis_tdata[13:0]);
            errors++;
          end
          if (m_axis_tlast !== ob.last) begin
            $error("frame_last expected %0d actual %0d", ob.last, m_axis_tlast);
            errors++;
          end
        end
        beats_out++;
        if (m_axis_tlast) frames_out++;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog: stop if nothing moves while work is outstanding
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pixel_q.size() == 0 && expected_q.size() == 0 && !s_axis_tvalid)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= 5000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic queue_pixel(input logic [15:0] raw, input logic bad);
    pix_item_t it;
    it.op = OP_PIXEL;
    it.raw = raw;
    it.bad = bad;
    pixel_q.push_back(it);
  endtask

  task automatic queue_flush(input int n);
    pix_item_t it;
    it.op = OP_FLUSH;
    for (int i = 0; i < n; i++) begin
      it.raw = $urandom;
      it.bad = $urandom_range(1);
      pixel_q.push_back(it);
    end
  endtask

  // wait until every beat is sent and answered, then let the core settle
  task automatic drain();
    while (pixel_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_width = val & 11'h7FF;
    else if (idx == REG_FRAME_HEIGHT) cfg_height = val & 11'h7FF;
    else if (idx == REG_ROLLING_WEIGHT) begin
      cfg_weight = val & 8'hFF;
      if (cfg_weight == 0) avg_valid = 1'b0;
    end
  endtask

  // weight goes to zero first so the store is never read outside the loaded frame
  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned wt);
    cfg_write(REG_ROLLING_WEIGHT, 0);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_write(REG_ROLLING_WEIGHT, wt);
  endtask

  task automatic queue_random(input int n, input int unsigned w);
    int r, bad_pct;
    logic [15:0] raw;
    bad_pct = 15;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) bad_pct = ($urandom_range(3) == 0) ? 70 : 15;
      r = $urandom_range(99);
      if (r < 4) begin
        queue_flush(1);
      end else begin
        r = $urandom_range(9);
        raw = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
        queue_pixel(raw, $urandom_range(99) < bad_pct);
      end
    end
    queue_flush(w + 2);
  endtask

  initial begin
    int unsigned w, h, wt;
    cfg_width = 1024;
    cfg_height = 1024;
    cfg_weight = 0;
    ring_head = 0;
    ring_pending = 0;
    next_pos = 0;
    avg_valid = 1'b0;
    errors = 0;
    beats_out = 0;
    frames_out = 0;
    items_in = 0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    send_idle = 25;
    recv_idle = 55;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // clamped height, partial frame; the next size change restarts the position
    set_frame(20, 2047, 0);
    for (int i = 0; i < 3 * 20; i++) queue_pixel($urandom, $urandom_range(99) < 20);
    queue_flush(22);
    drain();

    // directed: 3x3 frames, clamped low sizes
    set_frame(0, 1, 0);
    for (int i = 0; i < 9; i++) queue_pixel((i % 2) ? 16'hFFFF : 16'h0000, i == 4);
    for (int i = 0; i < 9; i++) queue_pixel(16'hFFFF - 16'(i), 1'b1);
    queue_flush(6);
    drain();
    set_frame(3, 3, 255);
    for (int i = 0; i < 9; i++) queue_pixel(16'hFFFF, 1'b0);
    for (int i = 0; i < 9; i++) queue_pixel(16'h0003, i == 4);
    queue_flush(5);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle = 55;
        recv_idle = 25;
      end else if (ph == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      w = $urandom_range(12, 3);
      h = $urandom_range(8, 3);
      wt = (ph == 0) ? 0 : (ph == 1) ? 255 : (ph == 2) ? 1 : $urandom_range(255);
      set_frame(w, h, wt);
      if (ph == 5) begin
        queue_random(45, w);
        hold_req = 1'b1;
        queue_random(45, w);
      end else if (ph == 7) begin
        queue_random(45, w);
        drain();
        queue_random(45, w);
      end else begin
        queue_random(90, w);
      end
      drain();
    end

    $display("Ran %0d input beats, %0d output beats over %0d frames;", items_in, beats_out,
             frames_out);
    $display("covered clamped sizes, weights 0..255, flushes, stalls and dense bad pixels.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[bad_pixel_fill_rolling_average_core.f]
hdl/bpf_pkg.sv
hdl/bpf_div.sv
hdl/bpf_datapath.sv
hdl/bpf_ctrl.sv
hdl/bad_pixel_fill_rolling_average_core.sv
test/testbench.sv
